// ----- hw/rtl/complex_binomial_term_generator_unit_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef COMPLEX_BINOMIAL_TERM_GENERATOR_UNIT_ASSERT_SVH
`define COMPLEX_BINOMIAL_TERM_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CBTG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbtg: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define CBTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbtg: next-cycle check failed");

`endif

// ----- hw/rtl/cbtg_pkg.sv -----
package cbtg_pkg;

  localparam int EXP_W         = 5;
  localparam int COEF_W        = 30;
  // C(n,k) * (n-k) for n up to 31 stays below 2^33
  localparam int PROD_W        = 33;
  localparam int DIV_W         = EXP_W + 1;
  localparam int CNT_W         = 6;
  localparam int DEF_MAX_POWER = 31;
  localparam int MUL_STEPS     = EXP_W;
  localparam int DIV_STEPS     = PROD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

// ----- hw/rtl/complex_binomial_term_generator_unit.sv -----
// Channel   Ports                                              Handshake
// request   power                                              start, busy
// result    coefficient, x_exponent, y_exponent, imaginary,    strobe
//           last_term
//
// Power n gives n+1 results in increasing k, one strobe cycle each.
// Between results: a shift-add multiply by n-k, then restoring division
// by k+1, one quotient bit a cycle.
// Synchronous reset returns to idle. busy is high from the accepting edge
// until the last result has been shown; results cannot be stalled.
`include "complex_binomial_term_generator_unit_assert.svh"

module complex_binomial_term_generator_unit
  import cbtg_pkg::*;
#(
  parameter int MAX_POWER = DEF_MAX_POWER
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [EXP_W-1:0]         power,
  output logic                     strobe,
  output logic signed [COEF_W-1:0] coefficient,
  output logic [EXP_W-1:0]         x_exponent,
  output logic [EXP_W-1:0]         y_exponent,
  output logic                     imaginary,
  output logic                     last_term
);

  localparam logic [EXP_W:0]   MAX_P = (EXP_W + 1)'(MAX_POWER);
  localparam logic [EXP_W-1:0] CAP   = EXP_W'(MAX_POWER);

  state_t              state, state_next;
  logic [EXP_W-1:0]    n;
  logic [EXP_W-1:0]    k;
  logic [COEF_W-1:0]   coef;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   mcand;
  logic [EXP_W-1:0]    mplier;
  logic [EXP_W-1:0]    rem;
  logic [CNT_W-1:0]    cnt;

  logic                take;
  logic [EXP_W-1:0]    n_sat;
  logic [DIV_W-1:0]    divisor;
  logic [DIV_W-1:0]    trial;
  logic                fits;
  logic                steps_done;

  assign take    = start && (state == ST_IDLE);
  assign n_sat   = ({1'b0, power} > MAX_P) ? CAP : power;
  assign divisor = {1'b0, k} + 1'b1;
  assign trial   = {rem, acc[PROD_W-1]};
  assign fits    = trial >= divisor;

  always_comb begin
    steps_done = 1'b0;
    unique case (state)
      ST_MUL:  steps_done = (cnt == CNT_W'(MUL_STEPS - 1));
      ST_DIV:  steps_done = (cnt == CNT_W'(DIV_STEPS - 1));
      default: steps_done = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take) state_next = ST_EMIT;
      ST_EMIT: state_next = (k == n) ? ST_IDLE : ST_MUL;
      ST_MUL:  if (steps_done) state_next = ST_DIV;
      ST_DIV:  if (steps_done) state_next = ST_EMIT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != ST_IDLE);
    strobe      = (state == ST_EMIT);
    coefficient = $signed(k[1] ? (~coef + 1'b1) : coef);
    x_exponent  = n - k;
    y_exponent  = k;
    imaginary   = k[0];
    last_term   = (k == n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          n    <= n_sat;
          k    <= '0;
          coef <= COEF_W'(1);
        end
      end
      ST_EMIT: begin
        acc    <= '0;
        mcand  <= PROD_W'(coef);
        mplier <= n - k;
        rem    <= '0;
        cnt    <= '0;
      end
      ST_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= mplier >> 1;
        cnt    <= steps_done ? '0 : cnt + 1'b1;
      end
      ST_DIV: begin
        rem <= fits ? EXP_W'(trial - divisor) : trial[EXP_W-1:0];
        acc <= {acc[PROD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (steps_done) begin
          coef <= {acc[COEF_W-2:0], fits};
          k    <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  `CBTG_ASSERT_NEXT(a_first_term, clk, rst, take, strobe && y_exponent == '0 && coefficient == COEF_W'(1))
  `CBTG_ASSERT_NEXT(a_last_ends, clk, rst, strobe && last_term, !busy)
  `CBTG_ASSERT_NOW(a_k_in_range, clk, rst, strobe, k <= n)
  `CBTG_ASSERT_NOW(a_exact_div, clk, rst, strobe && k != '0, rem == '0)

endmodule
